// ===== src/tedet_pkg.sv =====
// shared types and constants of the text encoding detector
// no dependencies
package tedet_pkg;

   localparam int CountBits = 32;
   localparam logic [CountBits-1:0] CountMax = '1;

   typedef enum logic [2:0] {
      EncUtf8    = 3'd0,
      EncUtf16Le = 3'd1,
      EncUtf16Be = 3'd2,
      EncCp1252  = 3'd3,
      EncBinary  = 3'd4
   } encoding_type;

   typedef enum logic [1:0] {
      BomNone = 2'd0,
      BomLe   = 2'd1,
      BomBe   = 2'd2
   } bom_type;

   typedef enum logic [2:0] {
      RangeFull  = 3'd0,
      RangeA0Bf  = 3'd1,
      Range809F  = 3'd2,
      Range90Bf  = 3'd3,
      Range808F  = 3'd4
   } range_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       last;
   } item_type;

   typedef struct packed {
      logic [CountBits-1:0] byte_count;
      logic [CountBits-1:0] odd_nul_count;
      logic [CountBits-1:0] even_nul_count;
      logic                 error_seen;
      logic [CountBits-1:0] error_position;
      bom_type              bom_kind;
      logic                 count_overflow;
   } summary_type;

endpackage

// ===== src/tedet_scan.sv =====
// per-byte scanner: counters, byte order mark and strict utf-8 check
// registers the stream summary at the end word; uses tedet_pkg
module tedet_scan
   import tedet_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        item_valid,
   input  item_type    item,
   output logic        item_ready,
   output logic        sum_valid,
   output summary_type sum,
   input  logic        sum_ready
);

   logic [CountBits-1:0] cnt_ff, cnt_in;
   logic [CountBits-1:0] odd_ff, odd_in;
   logic [CountBits-1:0] even_ff, even_in;
   logic [1:0]           left_ff, left_in;
   range_type            kind_ff, kind_in;
   logic [CountBits-1:0] start_ff, start_in;
   logic                 err_ff, err_in;
   logic [CountBits-1:0] errpos_ff, errpos_in;
   logic [7:0]           first_ff, first_in;
   bom_type              bom_ff, bom_in;
   logic                 ovf_ff, ovf_in;
   logic                 sum_valid_ff, sum_valid_in;
   summary_type          sum_ff, sum_in;
   logic                 free;
   logic                 step;

   function automatic logic in_range(range_type kind, logic [7:0] b);
      logic [7:0] lo;
      logic [7:0] hi;
      lo = 8'h80;
      hi = 8'hBF;
      case (kind)
         RangeA0Bf: lo = 8'hA0;
         Range809F: hi = 8'h9F;
         Range90Bf: lo = 8'h90;
         Range808F: hi = 8'h8F;
         default:   lo = 8'h80;
      endcase
      return (b >= lo) && (b <= hi);
   endfunction

   assign free       = !sum_valid_ff || sum_ready;
   assign item_ready = free;
   assign step       = item_valid && free;
   assign sum_valid  = sum_valid_ff;
   assign sum        = sum_ff;

   always_comb begin
      logic [CountBits-1:0] pos;
      logic [7:0]           b;
      cnt_in    = cnt_ff;
      odd_in    = odd_ff;
      even_in   = even_ff;
      left_in   = left_ff;
      kind_in   = kind_ff;
      start_in  = start_ff;
      err_in    = err_ff;
      errpos_in = errpos_ff;
      first_in  = first_ff;
      bom_in    = bom_ff;
      ovf_in    = ovf_ff;
      sum_in    = sum_ff;
      pos       = cnt_ff;
      b         = item.data_byte;
      sum_valid_in = free ? (item_valid && item.last) : sum_valid_ff;

      if (step && item.has_byte) begin
         if (cnt_ff != CountMax) cnt_in = cnt_ff + CountBits'(1);
         else ovf_in = 1'b1;

         if (pos == '0) first_in = b;
         else if (pos == CountBits'(1)) begin
            if (first_ff == 8'hFF && b == 8'hFE) bom_in = BomLe;
            else if (first_ff == 8'hFE && b == 8'hFF) bom_in = BomBe;
         end

         if (b == 8'h00) begin
            if (pos[0]) odd_in = (odd_ff != CountMax) ? odd_ff + CountBits'(1) : odd_ff;
            else even_in = (even_ff != CountMax) ? even_ff + CountBits'(1) : even_ff;
         end

         if (!err_ff) begin
            if (left_ff != 2'd0) begin
               if (!in_range(kind_ff, b)) begin
                  err_in    = 1'b1;
                  errpos_in = start_ff;
                  left_in   = 2'd0;
               end else begin
                  left_in = left_ff - 2'd1;
               end
               kind_in = RangeFull;
            end else if (b == 8'h00) begin
               err_in    = 1'b1;
               errpos_in = pos;
            end else if (b[7]) begin
               start_in = pos;
               kind_in  = RangeFull;
               case (b) inside
                  [8'hC2:8'hDF]: left_in = 2'd1;
                  8'hE0: begin
                     left_in = 2'd2;
                     kind_in = RangeA0Bf;
                  end
                  8'hED: begin
                     left_in = 2'd2;
                     kind_in = Range809F;
                  end
                  [8'hE1:8'hEF]: left_in = 2'd2;
                  8'hF0: begin
                     left_in = 2'd3;
                     kind_in = Range90Bf;
                  end
                  [8'hF1:8'hF3]: left_in = 2'd3;
                  8'hF4: begin
                     left_in = 2'd3;
                     kind_in = Range808F;
                  end
                  default: begin
                     err_in    = 1'b1;
                     errpos_in = pos;
                  end
               endcase
            end
         end
      end

      if (step && item.last) begin
         // a sequence cut off at the end counts from its lead byte
         if (!err_in && left_in != 2'd0) begin
            err_in    = 1'b1;
            errpos_in = start_in;
         end
         sum_in.byte_count     = cnt_in;
         sum_in.odd_nul_count  = odd_in;
         sum_in.even_nul_count = even_in;
         sum_in.error_seen     = err_in;
         sum_in.error_position = errpos_in;
         sum_in.bom_kind       = bom_in;
         sum_in.count_overflow = ovf_in;
         cnt_in    = '0;
         odd_in    = '0;
         even_in   = '0;
         left_in   = 2'd0;
         kind_in   = RangeFull;
         start_in  = '0;
         err_in    = 1'b0;
         errpos_in = '0;
         first_in  = 8'h00;
         bom_in    = BomNone;
         ovf_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         odd_ff       <= '0;
         even_ff      <= '0;
         left_ff      <= 2'd0;
         kind_ff      <= RangeFull;
         start_ff     <= '0;
         err_ff       <= 1'b0;
         errpos_ff    <= '0;
         first_ff     <= 8'h00;
         bom_ff       <= BomNone;
         ovf_ff       <= 1'b0;
         sum_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         odd_ff       <= odd_in;
         even_ff      <= even_in;
         left_ff      <= left_in;
         kind_ff      <= kind_in;
         start_ff     <= start_in;
         err_ff       <= err_in;
         errpos_ff    <= errpos_in;
         first_ff     <= first_in;
         bom_ff       <= bom_in;
         ovf_ff       <= ovf_in;
         sum_valid_ff <= sum_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
   end

endmodule

// ===== src/tedet_classify.sv =====
// end-of-stream classifier with the result register
// takes the stream summary from tedet_scan; uses tedet_pkg
module tedet_classify
   import tedet_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         sum_valid,
   input  summary_type  sum,
   output logic         sum_ready,
   output logic         out_valid,
   input  logic         out_ready,
   output encoding_type encoding,
   output logic         utf8_error,
   output logic [31:0]  error_offset,
   output logic         length_saturated
);

   logic         out_valid_ff, out_valid_in;
   encoding_type enc_ff, enc_in;
   logic         err_ff;
   logic [31:0]  off_ff, off_in;
   logic         sat_ff;
   logic         load;

   // nul * 4 >= h * 3
   function automatic logic enough_nuls(logic [CountBits-1:0] nul, logic [CountBits-1:0] h);
      logic [CountBits+1:0] lhs;
      logic [CountBits+1:0] rhs;
      lhs = {nul, 2'b00};
      rhs = (CountBits+2)'(h) + ((CountBits+2)'(h) << 1);
      return lhs >= rhs;
   endfunction

   assign sum_ready = !out_valid_ff || out_ready;
   assign load      = sum_valid && sum_ready;

   always_comb begin
      logic [CountBits-1:0] n;
      logic [CountBits-1:0] h;
      logic                 even_len;
      logic [63:0]          pos64;
      n        = sum.byte_count;
      h        = n >> 1;
      even_len = (n >= CountBits'(4)) && !n[0];
      pos64    = 64'(sum.error_position);

      if (sum.bom_kind == BomLe) enc_in = EncUtf16Le;
      else if (sum.bom_kind == BomBe) enc_in = EncUtf16Be;
      else if (!sum.error_seen) enc_in = EncUtf8;
      else if (even_len && sum.even_nul_count == '0 &&
               enough_nuls(sum.odd_nul_count, h)) enc_in = EncUtf16Le;
      else if (even_len && sum.odd_nul_count == '0 &&
               enough_nuls(sum.even_nul_count, h)) enc_in = EncUtf16Be;
      else if (sum.odd_nul_count == '0 && sum.even_nul_count == '0) enc_in = EncCp1252;
      else enc_in = EncBinary;

      if (!sum.error_seen) off_in = 32'h0;
      else if (pos64 > 64'hFFFF_FFFF) off_in = 32'hFFFF_FFFF;
      else off_in = pos64[31:0];

      out_valid_in = sum_ready ? sum_valid : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         enc_ff <= enc_in;
         err_ff <= sum.error_seen;
         off_ff <= off_in;
         sat_ff <= sum.count_overflow;
      end
   end

   assign out_valid        = out_valid_ff;
   assign encoding         = enc_ff;
   assign utf8_error       = err_ff;
   assign error_offset     = off_ff;
   assign length_saturated = sat_ff;

endmodule

// ===== src/text_encoding_detector.sv =====
// text encoding detector top level: input register, scanner, classifier
// depends on tedet_pkg, tedet_scan, tedet_classify
//
//   channel  direction  tdata                          tuser     tlast
//   req      in         data_byte[7:0]                 has_byte  end of stream
//   rsp      out        encoding, utf8_error, offset,  -         -
//                       length_saturated
//
// one word accepted per cycle while rsp is not stalled; no gaps between streams
// after the tlast word is taken, the summary register and then the result register load
// reset clears all counters and valid flags
// a stall on rsp holds two results and one input word, then drops req_tready
module text_encoding_detector
   import tedet_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] has_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // [2:0] encoding, [3] utf8_error,
                                    // [35:4] error_offset, [36] length_saturated
);

   logic         in_valid_ff, in_valid_in;
   item_type     in_ff;
   logic         item_ready;
   logic         sum_valid;
   summary_type  sum;
   logic         sum_ready;
   encoding_type encoding;
   logic         utf8_error;
   logic [31:0]  error_offset;
   logic         length_saturated;

   assign req_tready  = !in_valid_ff || item_ready;
   assign in_valid_in = req_tready ? req_tvalid : in_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_ff.data_byte <= req_tdata;
         in_ff.has_byte  <= req_tuser;
         in_ff.last      <= req_tlast;
      end
   end

   tedet_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .item_valid (in_valid_ff),
      .item       (in_ff),
      .item_ready (item_ready),
      .sum_valid  (sum_valid),
      .sum        (sum),
      .sum_ready  (sum_ready)
   );

   tedet_classify u_classify (
      .clock            (clock),
      .reset            (reset),
      .sum_valid        (sum_valid),
      .sum              (sum),
      .sum_ready        (sum_ready),
      .out_valid        (rsp_tvalid),
      .out_ready        (rsp_tready),
      .encoding         (encoding),
      .utf8_error       (utf8_error),
      .error_offset     (error_offset),
      .length_saturated (length_saturated)
   );

   assign rsp_tdata = {3'b000, length_saturated, error_offset, utf8_error, encoding};

   a_enc_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (encoding == EncUtf8 || encoding == EncUtf16Le ||
                      encoding == EncUtf16Be || encoding == EncCp1252 ||
                      encoding == EncBinary))
      else $error("encoding code out of range");

   a_no_err_offset: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !utf8_error) |-> (error_offset == 32'h0))
      else $error("error offset without utf-8 error");

   a_clean_utf8: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !utf8_error) |->
         (encoding == EncUtf8 || encoding == EncUtf16Le || encoding == EncUtf16Be))
      else $error("valid utf-8 stream classified as legacy encoding");

   a_sum_waits: assert property (@(posedge clock) disable iff (reset)
      (sum_valid && !sum_ready) |=> sum_valid)
      else $error("stream summary dropped while stalled");

endmodule
